// ----- sv/sfrp_pkg.sv -----
// Package for the filter rule parser: character codes, keyword tables, scanner
// state types and the per-character step functions of the token scanners.
// No dependencies; used by sfrp_token_scan and sdf_filter_rule_parser_core.
package sfrp_pkg;

  localparam int MAX_RULE_CHARS = 255;
  localparam int MAX_TOKENS     = 12;
  localparam int MIN_TOKENS     = 6;

  localparam logic [16:0] NUM_SAT    = 17'h1FFFF;
  localparam logic [7:0]  PROTO_ANY  = 8'hFF;
  localparam logic [15:0] PORT_MAX   = 16'hFFFF;
  localparam logic [5:0]  PREFIX_MAX = 6'd32;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam int NUM_KW        = 9;
  localparam int KW_PERMIT     = 0;
  localparam int KW_DENY       = 1;
  localparam int KW_IN         = 2;
  localparam int KW_OUT        = 3;
  localparam int KW_BIDIR      = 4;
  localparam int KW_IP         = 5;
  localparam int KW_FROM       = 6;
  localparam int KW_TO         = 7;
  localparam int KW_ANY        = 8;

  localparam logic [1:0] ACT_PERMIT = 2'd1;
  localparam logic [1:0] ACT_DENY   = 2'd2;
  localparam logic [1:0] DIR_IN     = 2'd1;
  localparam logic [1:0] DIR_OUT    = 2'd2;
  localparam logic [1:0] DIR_BIDIR  = 2'd3;

  localparam logic [3:0] TOK_ACTION   = 4'd0;
  localparam logic [3:0] TOK_DIR      = 4'd1;
  localparam logic [3:0] TOK_PROTO    = 4'd2;
  localparam logic [3:0] TOK_FROM     = 4'd3;
  localparam logic [3:0] TOK_SRC      = 4'd4;
  localparam logic [3:0] TOK_FIVE     = 4'd5;
  localparam logic [3:0] TOK_SIX      = 4'd6;
  localparam logic [3:0] TOK_SEVEN    = 4'd7;
  localparam logic [3:0] TOK_EIGHT    = 4'd8;

  typedef enum logic [2:0] {
    PH_WS   = 3'b001,
    PH_DIG  = 3'b010,
    PH_DONE = 3'b100
  } scan_phase_t;

  typedef struct packed {
    scan_phase_t phase;
    logic        neg;
    logic [15:0] val;
    logic [16:0] mag;
  } num_scan_t;

  localparam num_scan_t NUM_SCAN_INIT = '{phase: PH_WS, neg: 1'b0, val: 16'd0, mag: 17'd0};

  typedef struct packed {
    logic [23:0] acc;
    logic [7:0]  cur;
    logic [2:0]  octets;
    logic        digit;
    logic        fail;
  } quad_scan_t;

  typedef struct packed {
    logic [NUM_KW-1:0] kw_hit;
    logic [15:0]       low_val;
    logic [15:0]       high_val;
    logic              addr_ok;
    logic [31:0]       addr;
    logic [31:0]       mask;
  } tok_view_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [1:0]  direction;
    logic [7:0]  protocol;
    logic [31:0] source_address;
    logic [31:0] source_mask;
    logic [15:0] source_port_low;
    logic [15:0] source_port_high;
    logic [31:0] dest_address;
    logic [31:0] dest_mask;
    logic [15:0] dest_port_low;
    logic [15:0] dest_port_high;
  } rec_t;

  localparam rec_t REC_DEFAULT = '{
    action: 2'd0, direction: 2'd0, protocol: 8'd0,
    source_address: 32'd0, source_mask: 32'd0,
    source_port_low: 16'd0, source_port_high: PORT_MAX,
    dest_address: 32'd0, dest_mask: 32'd0,
    dest_port_low: 16'd0, dest_port_high: PORT_MAX
  };

  function automatic logic [3:0] kw_len(input int k);
    logic [3:0] n;
    unique case (k)
      KW_PERMIT: n = 4'd6;
      KW_DENY:   n = 4'd4;
      KW_IN:     n = 4'd2;
      KW_OUT:    n = 4'd3;
      KW_BIDIR:  n = 4'd13;
      KW_IP:     n = 4'd2;
      KW_FROM:   n = 4'd4;
      KW_TO:     n = 4'd2;
      KW_ANY:    n = 4'd3;
      default:   n = 4'd0;
    endcase
    return n;
  endfunction

  // Character at position pos of keyword k; the string is right-aligned.
  function automatic logic [7:0] kw_char(input int k, input logic [3:0] pos);
    logic [103:0] s;
    logic [3:0]   top;
    unique case (k)
      KW_PERMIT: s = 104'("permit");
      KW_DENY:   s = 104'("deny");
      KW_IN:     s = 104'("in");
      KW_OUT:    s = 104'("out");
      KW_BIDIR:  s = 104'("bidirectional");
      KW_IP:     s = 104'("ip");
      KW_FROM:   s = 104'("from");
      KW_TO:     s = 104'("to");
      KW_ANY:    s = 104'("any");
      default:   s = '0;
    endcase
    top = kw_len(k) - 4'd1 - pos;
    return s[8*top +: 8];
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  // One character of a C-style decimal scan: leading control whitespace,
  // optional sign, then digits until the first non-digit.
  function automatic num_scan_t num_step(input num_scan_t s, input logic [7:0] c);
    num_scan_t   n;
    logic [3:0]  d;
    logic [20:0] m;
    logic        take;
    n    = s;
    d    = 4'(c - CH_ZERO);
    m    = 21'(s.mag) * 21'd10 + 21'(d);
    take = 1'b0;
    unique case (s.phase)
      PH_WS: begin
        if (c == CH_NL || c == CH_VT || c == CH_FF || c == CH_CR) begin
          n.phase = PH_WS;
        end else if (c == CH_PLUS || c == CH_MINUS) begin
          n.neg   = (c == CH_MINUS);
          n.phase = PH_DIG;
        end else if (is_digit(c)) begin
          take    = 1'b1;
          n.phase = PH_DIG;
        end else begin
          n.phase = PH_DONE;
        end
      end
      PH_DIG: begin
        if (is_digit(c)) take = 1'b1;
        else n.phase = PH_DONE;
      end
      PH_DONE: n.phase = PH_DONE;
      default: n.phase = PH_DONE;
    endcase
    if (take) begin
      n.val = 16'(20'(s.val) * 20'd10 + 20'(d));
      n.mag = (m > 21'(NUM_SAT)) ? NUM_SAT : m[16:0];
    end
    return n;
  endfunction

  function automatic logic [15:0] num_value(input num_scan_t s);
    return s.neg ? 16'(16'd0 - s.val) : s.val;
  endfunction

  // One character of the dotted quad check; a failure is sticky.
  function automatic quad_scan_t quad_step(input quad_scan_t q, input logic [7:0] c);
    quad_scan_t n;
    logic [11:0] nv;
    n  = q;
    nv = 12'(q.cur) * 12'd10 + 12'(4'(c - CH_ZERO));
    if (!q.fail) begin
      if (is_digit(c)) begin
        if (q.digit && q.cur == 8'd0) begin
          n.fail = 1'b1;
        end else if (nv > 12'd255) begin
          n.fail = 1'b1;
        end else begin
          n.cur = nv[7:0];
          if (!q.digit) begin
            if (q.octets == 3'd4) begin
              n.fail = 1'b1;
            end else begin
              n.octets = q.octets + 3'd1;
              n.digit  = 1'b1;
            end
          end
        end
      end else if (c == CH_DOT && q.digit) begin
        if (q.octets == 3'd4) begin
          n.fail = 1'b1;
        end else begin
          n.acc   = {q.acc[15:0], q.cur};
          n.cur   = 8'd0;
          n.digit = 1'b0;
        end
      end else begin
        n.fail = 1'b1;
      end
    end
    return n;
  endfunction

endpackage

// ----- sv/sfrp_token_scan.sv -----
// Per-token scanner: keyword match flags, port and prefix number scans and
// the dotted quad check, updated one character at a time. Uses sfrp_pkg.
module sfrp_token_scan (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [7:0]          char_byte,
  input  logic                push,
  input  logic                clear,
  output sfrp_pkg::tok_view_t view,
  output logic [7:0]          tok_len
);
  import sfrp_pkg::*;

  logic [7:0]        cnt_r, cnt_nxt, v_cnt;
  logic [NUM_KW-1:0] kw_r, kw_nxt, v_kw;
  num_scan_t         low_r, low_nxt, v_low;
  num_scan_t         high_r, high_nxt, v_high;
  num_scan_t         pfx_r, pfx_nxt, v_pfx;
  quad_scan_t        quad_r, quad_nxt, v_quad;
  logic              dash_r, dash_nxt, v_dash;
  logic              slash_r, slash_nxt, v_slash;
  logic              pfx_ok;
  logic [5:0]        plen;

  always_comb begin
    cnt_nxt = cnt_r + 8'd1;
    for (int k = 0; k < NUM_KW; k++) begin
      kw_nxt[k] = kw_r[k] && (cnt_r < 8'(kw_len(k))) &&
                  (kw_char(k, cnt_r[3:0]) == char_byte);
    end
    low_nxt   = num_step(low_r, char_byte);
    high_nxt  = dash_r ? num_step(high_r, char_byte) : high_r;
    dash_nxt  = dash_r || (char_byte == CH_MINUS);
    pfx_nxt   = slash_r ? num_step(pfx_r, char_byte) : pfx_r;
    slash_nxt = slash_r || (char_byte == CH_SLASH);
    quad_nxt  = (!slash_r && char_byte != CH_SLASH) ? quad_step(quad_r, char_byte) : quad_r;
  end

  // The view includes the character of this cycle, so a token closed by the
  // final character is evaluated complete.
  assign v_cnt   = push ? cnt_nxt   : cnt_r;
  assign v_kw    = push ? kw_nxt    : kw_r;
  assign v_low   = push ? low_nxt   : low_r;
  assign v_high  = push ? high_nxt  : high_r;
  assign v_pfx   = push ? pfx_nxt   : pfx_r;
  assign v_quad  = push ? quad_nxt  : quad_r;
  assign v_dash  = push ? dash_nxt  : dash_r;
  assign v_slash = push ? slash_nxt : slash_r;

  assign pfx_ok = !v_slash || (!(v_pfx.neg && v_pfx.mag != 17'd0) &&
                               v_pfx.mag <= 17'(PREFIX_MAX));
  assign plen   = v_slash ? v_pfx.mag[5:0] : PREFIX_MAX;

  always_comb begin
    for (int k = 0; k < NUM_KW; k++) begin
      view.kw_hit[k] = v_kw[k] && (v_cnt == 8'(kw_len(k)));
    end
    view.low_val  = num_value(v_low);
    view.high_val = v_dash ? num_value(v_high) : num_value(v_low);
    if (view.kw_hit[KW_ANY]) begin
      view.addr_ok = 1'b1;
      view.addr    = 32'd0;
      view.mask    = 32'd0;
    end else begin
      view.addr_ok = !v_quad.fail && v_quad.octets == 3'd4 && pfx_ok;
      view.addr    = {v_quad.acc, v_quad.cur};
      view.mask    = ~(32'hFFFF_FFFF >> plen);
    end
  end

  assign tok_len = v_cnt;

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      cnt_r   <= 8'd0;
      kw_r    <= '1;
      low_r   <= NUM_SCAN_INIT;
      high_r  <= NUM_SCAN_INIT;
      pfx_r   <= NUM_SCAN_INIT;
      quad_r  <= '0;
      dash_r  <= 1'b0;
      slash_r <= 1'b0;
    end else if (push) begin
      cnt_r   <= cnt_nxt;
      kw_r    <= kw_nxt;
      low_r   <= low_nxt;
      high_r  <= high_nxt;
      pfx_r   <= pfx_nxt;
      quad_r  <= quad_nxt;
      dash_r  <= dash_nxt;
      slash_r <= slash_nxt;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    $past(clear) |-> cnt_r == 8'd0 && !dash_r && !slash_r)
    else $error("token scanner not cleared after token end");
  assert property (@(posedge clk) disable iff (!rst_n)
    quad_r.octets <= 3'd4)
    else $error("dotted quad octet count above four");
  assert property (@(posedge clk) disable iff (!rst_n)
    !slash_r |-> pfx_r == NUM_SCAN_INIT)
    else $error("prefix scan moved before a slash");

endmodule

// ----- sv/sdf_filter_rule_parser_core.sv -----
// Filter rule parser: one character per cycle; on the final character of a rule
// one record is registered at the output, and out_valid rises in the cycle after
// the final character is accepted. Throughput one character per cycle, with a character
// that is not final accepted even while a record waits. The only stall is a
// final character arriving while the output register is full and stalled.
// Synchronous active-low reset clears the rule state and the output valid.
module sdf_filter_rule_parser_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_char_byte,
  input  logic        in_is_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_status,
  output logic [1:0]  out_action,
  output logic [1:0]  out_direction,
  output logic [7:0]  out_protocol,
  output logic [31:0] out_source_address,
  output logic [31:0] out_source_mask,
  output logic [15:0] out_source_port_low,
  output logic [15:0] out_source_port_high,
  output logic [31:0] out_dest_address,
  output logic [31:0] out_dest_mask,
  output logic [15:0] out_dest_port_low,
  output logic [15:0] out_dest_port_high
);
  import sfrp_pkg::*;

  logic       acc, active, is_sep, is_nul, push, end_tok, take, rule_done, bad;
  logic [7:0] chars_r, chars_nxt;
  logic       stopped_r, stopped_nxt;
  logic [3:0] tidx_r, tidx_nxt;
  logic       sps_r, sps_nxt;
  logic       err_r, err_nxt;
  rec_t       rec_r, rec_nxt;
  logic       out_valid_r;
  logic       out_status_r;
  rec_t       out_rec_r;
  tok_view_t  view;
  logic [7:0] tok_len;

  assign in_stall  = out_valid_r && out_stall && in_is_last;
  assign acc       = in_valid && !in_stall;
  assign active    = !stopped_r && (chars_r != 8'(MAX_RULE_CHARS));
  assign is_sep    = (in_char_byte == CH_SPACE) || (in_char_byte == CH_TAB);
  assign is_nul    = (in_char_byte == CH_NUL);
  assign push      = acc && active && !is_nul && !is_sep;
  assign end_tok   = acc && ((active && is_sep) || in_is_last);
  assign take      = end_tok && (tok_len != 8'd0) && (tidx_r < 4'(MAX_TOKENS));
  assign rule_done = acc && in_is_last;

  sfrp_token_scan u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .char_byte (in_char_byte),
    .push      (push),
    .clear     (end_tok),
    .view      (view),
    .tok_len   (tok_len)
  );

  // Each completed token is applied to the record by its position in the rule.
  always_comb begin
    rec_nxt     = rec_r;
    err_nxt     = err_r;
    sps_nxt     = sps_r;
    tidx_nxt    = tidx_r + 4'(take);
    chars_nxt   = chars_r + 8'(acc && active);
    stopped_nxt = stopped_r || (acc && active && is_nul);
    if (take) begin
      unique case (tidx_r)
        TOK_ACTION: begin
          if (view.kw_hit[KW_PERMIT]) rec_nxt.action = ACT_PERMIT;
          else if (view.kw_hit[KW_DENY]) rec_nxt.action = ACT_DENY;
          else err_nxt = 1'b1;
        end
        TOK_DIR: begin
          if (view.kw_hit[KW_IN]) rec_nxt.direction = DIR_IN;
          else if (view.kw_hit[KW_OUT]) rec_nxt.direction = DIR_OUT;
          else if (view.kw_hit[KW_BIDIR]) rec_nxt.direction = DIR_BIDIR;
          else err_nxt = 1'b1;
        end
        TOK_PROTO: begin
          rec_nxt.protocol = view.kw_hit[KW_IP] ? PROTO_ANY : view.low_val[7:0];
        end
        TOK_FROM: begin
          if (!view.kw_hit[KW_FROM]) err_nxt = 1'b1;
        end
        TOK_SRC: begin
          if (view.addr_ok) begin
            rec_nxt.source_address = view.addr;
            rec_nxt.source_mask    = view.mask;
          end else begin
            err_nxt = 1'b1;
          end
        end
        TOK_FIVE: begin
          if (!view.kw_hit[KW_TO]) begin
            sps_nxt                  = 1'b1;
            rec_nxt.source_port_low  = view.low_val;
            rec_nxt.source_port_high = view.high_val;
          end
        end
        TOK_SIX: begin
          if (!sps_r) begin
            if (view.addr_ok) begin
              rec_nxt.dest_address = view.addr;
              rec_nxt.dest_mask    = view.mask;
            end else begin
              err_nxt = 1'b1;
            end
          end else if (!view.kw_hit[KW_TO]) begin
            err_nxt = 1'b1;
          end
        end
        TOK_SEVEN: begin
          if (!sps_r) begin
            rec_nxt.dest_port_low  = view.low_val;
            rec_nxt.dest_port_high = view.high_val;
          end else if (view.addr_ok) begin
            rec_nxt.dest_address = view.addr;
            rec_nxt.dest_mask    = view.mask;
          end else begin
            err_nxt = 1'b1;
          end
        end
        TOK_EIGHT: begin
          if (sps_r) begin
            rec_nxt.dest_port_low  = view.low_val;
            rec_nxt.dest_port_high = view.high_val;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign bad = err_nxt || (tidx_nxt < 4'(MIN_TOKENS)) ||
               (tidx_nxt < (sps_nxt ? 4'd8 : 4'd7));

  always_ff @(posedge clk) begin
    if (!rst_n || rule_done) begin
      chars_r   <= 8'd0;
      stopped_r <= 1'b0;
      tidx_r    <= 4'd0;
      sps_r     <= 1'b0;
      err_r     <= 1'b0;
      rec_r     <= REC_DEFAULT;
    end else if (acc) begin
      chars_r   <= chars_nxt;
      stopped_r <= stopped_nxt;
      tidx_r    <= tidx_nxt;
      sps_r     <= sps_nxt;
      err_r     <= err_nxt;
      rec_r     <= rec_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rule_done) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rule_done) begin
      out_status_r <= bad;
      out_rec_r    <= bad ? REC_DEFAULT : rec_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_status           = out_status_r;
  assign out_action           = out_rec_r.action;
  assign out_direction        = out_rec_r.direction;
  assign out_protocol         = out_rec_r.protocol;
  assign out_source_address   = out_rec_r.source_address;
  assign out_source_mask      = out_rec_r.source_mask;
  assign out_source_port_low  = out_rec_r.source_port_low;
  assign out_source_port_high = out_rec_r.source_port_high;
  assign out_dest_address     = out_rec_r.dest_address;
  assign out_dest_mask        = out_rec_r.dest_mask;
  assign out_dest_port_low    = out_rec_r.dest_port_low;
  assign out_dest_port_high   = out_rec_r.dest_port_high;

  assert property (@(posedge clk) disable iff (!rst_n)
    tidx_r <= 4'(MAX_TOKENS))
    else $error("token index beyond the token limit");
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(acc && in_is_last))
    else $error("record shown without a final character");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r |-> out_rec_r.action == 2'd0 &&
      out_rec_r.source_port_high == PORT_MAX && out_rec_r.dest_port_high == PORT_MAX)
    else $error("malformed record not cleared to defaults");
  assert property (@(posedge clk) disable iff (!rst_n)
    stopped_r |-> chars_r != 8'd0)
    else $error("stopped without any character counted");

endmodule
